@@ design/pdrt_pkg.sv @@
// ----------------------------------------------------------------------------
// pdrt_pkg: shared types and constants for the point decimate / transform core
// Item structs, field widths, register indexes and the coordinate saturator.
// ----------------------------------------------------------------------------
package pdrt_pkg;

  localparam int COORD_W    = 24;   // point and result coordinate width
  localparam int TOTAL_W    = 19;   // frame point count width
  localparam int MP_W       = 16;   // point cap register width
  localparam int COEF_W     = 16;   // one rotation coefficient
  localparam int ROT_W      = 3 * COEF_W;
  localparam int TRANS_W    = 20;   // one translation offset
  localparam int TRANS_ALL_W = 3 * TRANS_W;
  localparam int PROD_W     = COEF_W + COORD_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int SUM_W      = ACC_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [TOTAL_W-1:0] MAX_FRAME_POINTS = TOTAL_W'(262144);
  localparam logic [MP_W-1:0]    POINT_CAP_RESET  = MP_W'(30000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_CAP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_ROW2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSLATION = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic [TOTAL_W-1:0]        frame_total;
    logic                      frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] oz;
    logic [TOTAL_W-1:0]        selected_total;
    logic                      last;
  } out_item_t;

  // selected point on its way from the front to the back
  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic [TOTAL_W-1:0]        selected_total;
    logic                      last;
  } sel_point_t;

  typedef struct packed {
    logic                        enable;
    logic [2:0][ROT_W-1:0]       rot;
    logic [TRANS_ALL_W-1:0]      trans;
  } xform_cfg_t;

  // clamp to the signed coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] upper;
    upper = v[SUM_W-1:COORD_W-1];
    if (upper == '0 || upper == '1) begin
      sat_coord = v[COORD_W-1:0];
    end else if (v[SUM_W-1]) begin
      sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ design/pdrt_div.sv @@
// ----------------------------------------------------------------------------
// pdrt_div: restoring divider, one quotient bit per cycle
// Unsigned TOTAL_W-bit division; done pulses one cycle with the quotient.
// ----------------------------------------------------------------------------
module pdrt_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pdrt_pkg::TOTAL_W-1:0]  dividend,
  input  logic [pdrt_pkg::TOTAL_W-1:0]  divisor,
  output logic                          done,
  output logic [pdrt_pkg::TOTAL_W-1:0]  quotient
);
  import pdrt_pkg::*;

  localparam int STEP_W = $clog2(TOTAL_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TOTAL_W - 1);

  logic               running;
  logic [STEP_W-1:0]  step;
  logic [TOTAL_W-1:0] rem;
  logic [TOTAL_W-1:0] quo;
  logic [TOTAL_W-1:0] dsr;
  logic [TOTAL_W:0]   trial;
  logic [TOTAL_W:0]   diff;
  logic               fits;

  always_comb begin
    trial = {rem, quo[TOTAL_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // shift the dividend through, subtract where the divisor fits
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (running) begin
      rem <= fits ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
      quo <= {quo[TOTAL_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

@@ design/pdrt_fifo.sv @@
// ----------------------------------------------------------------------------
// pdrt_fifo: short queue of selected points between front and back
// Flop-based, QUEUE_DEPTH entries, head visible without a read cycle.
// ----------------------------------------------------------------------------
module pdrt_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  pdrt_pkg::sel_point_t    push_data,
  output logic                    full,
  input  logic                    pop,
  output pdrt_pkg::sel_point_t    pop_data,
  output logic                    empty
);
  import pdrt_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sel_point_t          mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;

  assign full     = count == CNT_W'(QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("pdrt_fifo: push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pdrt_fifo: pop from an empty queue");
`endif

endmodule

@@ design/pdrt_front.sv @@
// ----------------------------------------------------------------------------
// pdrt_front: frame setup and point selection
// Latches the frame size, derives stride and selected count on the shared
// divider, then picks every stride-th point into the queue.
// ----------------------------------------------------------------------------
module pdrt_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  pdrt_pkg::in_item_t          in_data,
  input  logic [pdrt_pkg::MP_W-1:0]   point_cap,
  output logic                        q_push,
  output pdrt_pkg::sel_point_t        q_data,
  input  logic                        q_full
);
  import pdrt_pkg::*;

  localparam logic [1:0] ST_IDLE       = 2'd0;
  localparam logic [1:0] ST_DIV_STRIDE = 2'd1;
  localparam logic [1:0] ST_DIV_SEL    = 2'd2;
  localparam logic [1:0] ST_EMIT       = 2'd3;

  logic [1:0]         state;
  logic [TOTAL_W-1:0] point_index;
  logic [TOTAL_W-1:0] stride;
  logic [TOTAL_W-1:0] skip;
  logic [TOTAL_W-1:0] sel_total;
  logic [TOTAL_W-1:0] frame_size;
  in_item_t           hold;

  logic               div_start;
  logic               div_done;
  logic [TOTAL_W-1:0] div_dividend;
  logic [TOTAL_W-1:0] div_divisor;
  logic [TOTAL_W-1:0] div_quot;

  logic [TOTAL_W-1:0] total_sat;
  logic [TOTAL_W-1:0] mp_eff;
  logic [TOTAL_W-1:0] stride_new;
  logic               accept;
  logic               take_frame;
  logic               proc_en;
  logic               active;
  logic               pick;
  logic               is_last;
  in_item_t           cur;

  pdrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    in_ready   = (state == ST_IDLE) && !q_full;
    accept     = in_valid && in_ready;
    take_frame = accept && in_data.frame_start;
    total_sat  = (in_data.frame_total > MAX_FRAME_POINTS) ? MAX_FRAME_POINTS
                                                          : in_data.frame_total;
    mp_eff     = (point_cap == '0) ? TOTAL_W'(1) : TOTAL_W'(point_cap);
    stride_new = (div_quot == '0) ? TOTAL_W'(1) : div_quot;

    // first pass: ceil(total / point cap); second pass: (total - 1) / stride
    div_start = take_frame || ((state == ST_DIV_STRIDE) && div_done);
    if (state == ST_DIV_STRIDE) begin
      div_dividend = frame_size - TOTAL_W'(1);
      div_divisor  = stride_new;
    end else begin
      div_dividend = total_sat + mp_eff - TOTAL_W'(1);
      div_divisor  = mp_eff;
    end

    cur     = (state == ST_EMIT) ? hold : in_data;
    proc_en = (accept && !in_data.frame_start) || ((state == ST_EMIT) && !q_full);
    active  = point_index < frame_size;
    pick    = active && (skip == '0);
    is_last = ({1'b0, point_index} + {1'b0, stride}) >= {1'b0, frame_size};

    q_push               = proc_en && pick;
    q_data.px            = cur.px;
    q_data.py            = cur.py;
    q_data.pz            = cur.pz;
    q_data.selected_total = sel_total;
    q_data.last          = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_index <= '0;
      stride      <= TOTAL_W'(1);
      skip        <= '0;
      sel_total   <= '0;
      frame_size  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take_frame) begin
            state <= ST_DIV_STRIDE;
          end
        end
        ST_DIV_STRIDE: begin
          if (div_done) begin
            stride <= stride_new;
            state  <= ST_DIV_SEL;
          end
        end
        ST_DIV_SEL: begin
          if (div_done) begin
            sel_total <= (frame_size == '0) ? '0 : div_quot + TOTAL_W'(1);
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!q_full) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (take_frame) begin
        frame_size  <= total_sat;
        point_index <= '0;
        skip        <= '0;
      end

      // advance the frame position; points past the frame size are dropped
      if (proc_en && active) begin
        point_index <= point_index + TOTAL_W'(1);
        skip        <= pick ? stride - TOTAL_W'(1) : skip - TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_frame) begin
      hold <= in_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    point_index <= frame_size)
    else $error("pdrt_front: point index ran past the frame size");
  a_skip_bound: assert property (@(posedge clk) disable iff (rst) skip < stride)
    else $error("pdrt_front: skip countdown not below stride");
  a_frame_blocks: assert property (@(posedge clk) disable iff (rst)
    take_frame |=> !in_ready)
    else $error("pdrt_front: input open during frame setup");
`endif

endmodule

@@ design/pdrt_back.sv @@
// ----------------------------------------------------------------------------
// pdrt_back: rigid transform pipeline
// Multiply, round and shift, translate and saturate; one stall for all stages.
// ----------------------------------------------------------------------------
module pdrt_back #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst,
  input  pdrt_pkg::xform_cfg_t      cfg,
  input  logic                      q_empty,
  output logic                      q_pop,
  input  pdrt_pkg::sel_point_t      q_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pdrt_pkg::out_item_t       out_data
);
  import pdrt_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));

  logic                       advance;
  logic                       s1_valid;
  logic                       s2_valid;
  logic                       s3_valid;
  sel_point_t                 s1_pt;
  sel_point_t                 s2_pt;
  out_item_t                  s3_data;

  logic signed [COORD_W-1:0]  coord_in [3];
  logic signed [COEF_W-1:0]   coef     [3][3];
  logic signed [PROD_W-1:0]   prod     [3][3];
  logic signed [ACC_W-1:0]    acc      [3];
  logic signed [ACC_W-1:0]    rnd      [3];
  logic signed [TRANS_W-1:0]  trans    [3];
  logic signed [SUM_W-1:0]    sum      [3];
  logic [COORD_W-1:0]         res      [3];
  logic [COORD_W-1:0]         pass     [3];

  assign advance   = !s3_valid || out_ready;
  assign q_pop     = advance && !q_empty;
  assign out_valid = s3_valid;
  assign out_data  = s3_data;

  always_comb begin
    coord_in[0] = q_data.px;
    coord_in[1] = q_data.py;
    coord_in[2] = q_data.pz;
    pass[0]     = s2_pt.px;
    pass[1]     = s2_pt.py;
    pass[2]     = s2_pt.pz;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        coef[r][k] = cfg.rot[r][k*COEF_W +: COEF_W];
      end
      trans[r] = cfg.trans[r*TRANS_W +: TRANS_W];
      acc[r]   = ACC_W'(prod[r][0]) + ACC_W'(prod[r][1]) + ACC_W'(prod[r][2]) + ROUND_BIAS;
      sum[r]   = SUM_W'(rnd[r]) + SUM_W'(trans[r]);
      res[r]   = cfg.enable ? sat_coord(sum[r]) : pass[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= q_pop;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r][k] <= coef[r][k] * coord_in[k];
        end
        // floor shift of the biased sum: round half up
        rnd[r] <= acc[r] >>> COEF_FRAC_BITS;
      end
      s1_pt                  <= q_data;
      s2_pt                  <= s1_pt;
      s3_data.ox             <= res[0];
      s3_data.oy             <= res[1];
      s3_data.oz             <= res[2];
      s3_data.selected_total <= s2_pt.selected_total;
      s3_data.last           <= s2_pt.last;
    end
  end

endmodule

@@ design/point_decimate_rigid_transform_core.sv @@
// ----------------------------------------------------------------------------
// point_decimate_rigid_transform_core: point decimation with rigid transform
// Throughput: one point per cycle inside a frame while the queue is not full; a
// frame_start transfer closes the input until both divider passes and its emit are done.
// Path: a selected point goes through the queue and the back pipeline to out_valid.
// Reset (synchronous): counters clear, stride is 1, registers return to defaults.
// ----------------------------------------------------------------------------
module point_decimate_rigid_transform_core #(
  parameter int COEF_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pdrt_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pdrt_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pdrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pdrt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pdrt_pkg::*;

  // Front: takes each input transfer. A frame_start point latches the
  // saturated frame size and runs two passes of a shared bit-serial divider:
  // stride = ceil(total / point cap), then selected = (total - 1) / stride + 1
  // (0 for an empty frame). Other points are classified in the cycle they
  // arrive. Back: three-stage multiply / round / saturate pipeline fed from
  // a four-entry queue, so an output stall does not stop the front until
  // the queue fills.

  // configuration registers; the user must write them only while the block is idle (not enforced here)
  logic                     transform_enable;
  logic [MP_W-1:0]          point_cap;
  logic [ROT_W-1:0]         rot_row0;
  logic [ROT_W-1:0]         rot_row1;
  logic [ROT_W-1:0]         rot_row2;
  logic [TRANS_ALL_W-1:0]   translation;
  xform_cfg_t               xcfg;

  // queue between front and back
  logic                     q_push;
  logic                     q_full;
  logic                     q_pop;
  logic                     q_empty;
  sel_point_t               q_wdata;
  sel_point_t               q_rdata;

  // the register file never stalls a write transfer
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      transform_enable <= 1'b0;
      point_cap        <= POINT_CAP_RESET;
      rot_row0         <= '0;
      rot_row1         <= '0;
      rot_row2         <= '0;
      translation      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENABLE:      transform_enable <= cfg_data[0];
        REG_POINT_CAP:   point_cap        <= cfg_data[MP_W-1:0];
        REG_ROT_ROW0:    rot_row0         <= cfg_data[ROT_W-1:0];
        REG_ROT_ROW1:    rot_row1         <= cfg_data[ROT_W-1:0];
        REG_ROT_ROW2:    rot_row2         <= cfg_data[ROT_W-1:0];
        REG_TRANSLATION: translation      <= cfg_data[TRANS_ALL_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  // bundle the transform settings for the back
  always_comb begin
    xcfg.enable = transform_enable;
    xcfg.rot[0] = rot_row0;
    xcfg.rot[1] = rot_row1;
    xcfg.rot[2] = rot_row2;
    xcfg.trans  = translation;
  end

  // frame setup, stride decimation, last-point marking
  pdrt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .point_cap  (point_cap),
    .q_push     (q_push),
    .q_data     (q_wdata),
    .q_full     (q_full)
  );

  // decouple selection from the transform so each side stalls on its own
  pdrt_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // rotation plus translation, saturated to the coordinate width, or pass-through when disabled
  pdrt_back #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (xcfg),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_data    (q_rdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ verif/point_decimate_rigid_transform_core_test.sv @@
// ----------------------------------------------------------------------------
// point_decimate_rigid_transform_core_test: self-checking bench for the core
// Drives framed point streams through the decimator and transform. Each
// accepted point runs through a local stride/transform predictor. Each output
// transfer is checked field by field against the oldest expected point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_decimate_rigid_transform_core_test;
  import pdrt_pkg::*;

  localparam int FRAC_BITS    = 14;      // rotation coefficient fraction bits
  localparam int DRAIN_CYCLES = 64;      // covers the frame_start latency
  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest clean run
  localparam int PHASE_ITEMS  = 64;      // random points per configuration phase
  localparam int RANDOM_PHASES = 9;

  typedef enum int {RX_FLOW, RX_RANDOM, RX_WINDOW} rx_mode_t;

  // DUT ports; every input starts at a known value
  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b1;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers (reset values)
  logic              xf_enable = 1'b0;
  logic [MP_W-1:0]   keep_max = POINT_CAP_RESET;
  logic [ROT_W-1:0]  rot_rows [3] = '{default: '0};
  logic [TRANS_ALL_W-1:0] offsets = '0;

  // predictor copy of the frame counters (reset values)
  int unsigned pt_count = 0;
  int unsigned stride = 1;
  int unsigned skip_left = 0;
  int unsigned sel_count = 0;
  int unsigned frame_len = 0;

  out_item_t expected_points [$];
  int        err_count = 0;
  int        items_sent = 0;
  int        burst_left = 0;
  int        cycle_count = 0;

  rx_mode_t  rx_mode = RX_FLOW;
  int        rx_left = 0;
  int        rx_hold = 0;

  point_decimate_rigid_transform_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the stream ever hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d points still expected",
               cycle_count, expected_points.size());
      $display("point_decimate_rigid_transform_core_test: done, errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------

  // Clamp to the signed coordinate range.
  function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
    if (v > 64'sd8388607) return 24'h7FFFFF;
    if (v < -64'sd8388608) return 24'h800000;
    return v[COORD_W-1:0];
  endfunction

  // One output row: exact dot product, round half up, add offset, clamp.
  function automatic logic [COORD_W-1:0] xform_row(input logic [ROT_W-1:0] row,
                                                   input in_item_t pt,
                                                   input logic [TRANS_W-1:0] ofs);
    longint acc;
    longint v;
    acc = longint'($signed(row[15:0]))  * longint'($signed(pt.px))
        + longint'($signed(row[31:16])) * longint'($signed(pt.py))
        + longint'($signed(row[47:32])) * longint'($signed(pt.pz));
    acc = acc + (64'sd1 <<< (FRAC_BITS - 1));
    v = (acc >>> FRAC_BITS) + longint'($signed(ofs));
    return clamp_coord(v);
  endfunction

  // Advance the frame counters for one accepted point and queue its result.
  function automatic void predict_point(input in_item_t it);
    int unsigned total;
    int unsigned mp;
    bit          take;
    bit          fin;
    out_item_t   r;
    if (it.frame_start) begin
      total = it.frame_total;
      if (total > MAX_FRAME_POINTS) total = MAX_FRAME_POINTS;
      mp = keep_max;
      if (mp == 0) mp = 1;
      stride = (total + mp - 1) / mp;
      if (stride == 0) stride = 1;
      frame_len = total;
      sel_count = (total == 0) ? 0 : (total - 1) / stride + 1;
      pt_count = 0;
      skip_left = 0;
    end
    // past the end of the frame, or no frame yet: drop
    if (pt_count >= frame_len) return;
    take = (skip_left == 0);
    if (take) skip_left = stride - 1;
    else skip_left--;
    fin = (pt_count + stride) >= frame_len;
    pt_count++;
    if (!take) return;
    if (xf_enable) begin
      r.ox = xform_row(rot_rows[0], it, offsets[19:0]);
      r.oy = xform_row(rot_rows[1], it, offsets[39:20]);
      r.oz = xform_row(rot_rows[2], it, offsets[59:40]);
    end else begin
      r.ox = it.px;
      r.oy = it.py;
      r.oz = it.pz;
    end
    r.selected_total = sel_count[TOTAL_W-1:0];
    r.last = fin;
    expected_points = {expected_points, r};
  endfunction

  // Mirror one register transfer into the predictor.
  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_ENABLE:      xf_enable = data[0];
      REG_POINT_CAP:   keep_max = data[MP_W-1:0];
      REG_ROT_ROW0:    rot_rows[0] = data[ROT_W-1:0];
      REG_ROT_ROW1:    rot_rows[1] = data[ROT_W-1:0];
      REG_ROT_ROW2:    rot_rows[2] = data[ROT_W-1:0];
      REG_TRANSLATION: offsets = data[TRANS_ALL_W-1:0];
      default: ;
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Result checking
  // ------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Compare every output transfer against the oldest expected point.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", out_data));
      end else begin
        want = expected_points.pop_front();
        if (out_data.ox !== want.ox)
          report_mismatch($sformatf("ox got %h want %h", out_data.ox, want.ox));
        if (out_data.oy !== want.oy)
          report_mismatch($sformatf("oy got %h want %h", out_data.oy, want.oy));
        if (out_data.oz !== want.oz)
          report_mismatch($sformatf("oz got %h want %h", out_data.oz, want.oz));
        if (out_data.selected_total !== want.selected_total)
          report_mismatch($sformatf("selected_total got %0d want %0d",
                                    out_data.selected_total, want.selected_total));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last got %b want %b", out_data.last, want.last));
      end
    end
  end

  // Receiver: switch between free flow, random stalls and a stall window.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    case (rx_mode)
      RX_FLOW:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      default: begin
        // hold ready low for the tail of each window
        if (rx_hold == 0) rx_hold = $urandom_range(2, 16);
        rx_hold--;
        out_ready <= (rx_hold >= 5);
      end
    endcase
  end

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  function automatic in_item_t make_point(input logic [COORD_W-1:0] x,
                                          input logic [COORD_W-1:0] y,
                                          input logic [COORD_W-1:0] z,
                                          input logic [TOTAL_W-1:0] total,
                                          input logic start);
    in_item_t it;
    it.px = x;
    it.py = y;
    it.pz = z;
    it.frame_total = total;
    it.frame_start = start;
    return it;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return COORD_W'($urandom_range(0, 2000) - 1000);
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Non-start points carry a junk frame_total, which the core must ignore.
  function automatic in_item_t rand_point(input bit start, input int unsigned total);
    logic [TOTAL_W-1:0] t;
    t = start ? TOTAL_W'(total) : TOTAL_W'($urandom);
    return make_point(rand_coord(), rand_coord(), rand_coord(), t, start);
  endfunction

  // Present one point and hold it until the transfer; the sender runs in
  // bursts with random gaps, and sometimes long bursts with no gap at all.
  task automatic send_point(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(30, 60);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, 8);
      end
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_point(it);
    items_sent++;
  endtask

  // Drop valid, wait for every expected point, then let in-flight
  // frame_start work finish.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  // Write the whole register file while the core is idle.
  task automatic write_all_regs(input logic en, input logic [MP_W-1:0] mp,
                                input logic [ROT_W-1:0] r0,
                                input logic [ROT_W-1:0] r1,
                                input logic [ROT_W-1:0] r2,
                                input logic [TRANS_ALL_W-1:0] tr);
    wait_idle();
    write_reg(REG_ENABLE, CFG_DATA_W'(en));
    write_reg(REG_POINT_CAP, CFG_DATA_W'(mp));
    write_reg(REG_ROT_ROW0, CFG_DATA_W'(r0));
    write_reg(REG_ROT_ROW1, CFG_DATA_W'(r1));
    write_reg(REG_ROT_ROW2, CFG_DATA_W'(r2));
    write_reg(REG_TRANSLATION, CFG_DATA_W'(tr));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ROT_W-1:0] rand_row();
    logic [63:0] r64;
    logic [COEF_W-1:0] c [3];
    if ($urandom_range(0, 1) == 0) begin
      r64 = {$urandom, $urandom};
      return r64[ROT_W-1:0];
    end
    // coefficients within +-1.0, like a real rotation
    for (int k = 0; k < 3; k++) c[k] = COEF_W'($urandom_range(0, 32768) - 16384);
    return {c[2], c[1], c[0]};
  endfunction

  task automatic set_random_config();
    logic [63:0]        r64;
    logic [MP_W-1:0]    mp;
    logic [TRANS_ALL_W-1:0] tr;
    logic [TRANS_W-1:0] t [3];
    case ($urandom_range(0, 5))
      0, 1, 2: mp = MP_W'($urandom_range(1, 6));
      3:       mp = MP_W'($urandom_range(1, 65535));
      4:       mp = 16'd1;
      default: mp = 16'hFFFF;
    endcase
    if ($urandom_range(0, 1) == 0) begin
      r64 = {$urandom, $urandom};
      tr = r64[TRANS_ALL_W-1:0];
    end else begin
      for (int k = 0; k < 3; k++) t[k] = TRANS_W'($urandom_range(0, 4000) - 2000);
      tr = {t[2], t[1], t[0]};
    end
    write_all_regs($urandom_range(0, 3) != 0, mp, rand_row(), rand_row(), rand_row(), tr);
  endtask

  // Mostly complete frames with random content; the rest are overruns,
  // abandoned frames, huge totals, empty frames and stray points.
  task automatic send_random_frame();
    int          pick;
    int unsigned total;
    int          count;
    bit          with_start;
    pick = $urandom_range(0, 19);
    with_start = 1'b1;
    if (pick < 12) begin
      total = $urandom_range(1, 24);
      count = total + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
    end else if (pick < 15) begin
      total = $urandom_range(5, 40);
      count = $urandom_range(1, total - 1);
    end else if (pick < 17) begin
      total = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 19'h7FFFF)
                                          : $urandom_range(262140, 262150);
      count = $urandom_range(1, 12);
    end else if (pick < 19) begin
      total = 0;
      count = $urandom_range(1, 3);
    end else begin
      total = 0;
      with_start = 1'b0;
      count = $urandom_range(1, 4);
    end
    for (int k = 0; k < count; k++) send_point(rand_point(with_start && k == 0, total));
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // Reset defaults: pass-through, point cap 30000.
  task automatic test_frame_basics();
    // no frame yet: drop
    send_point(make_point(24'h800000, 24'h7FFFFF, 24'h000000, 19'd5, 1'b0));
    send_point(make_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 19'd3, 1'b1));
    send_point(make_point(24'h800000, 24'h800000, 24'h800000, 19'h7FFFF, 1'b0));
    send_point(make_point(24'h000000, 24'hFFFFFF, 24'h555555, 19'd0, 1'b0));
    // past the end of the frame: drop
    send_point(make_point(24'hAAAAAA, 24'h123456, 24'hFEDCBA, 19'd9, 1'b0));
  endtask

  task automatic test_empty_frame();
    send_point(make_point(24'h111111, 24'h222222, 24'h333333, 19'd0, 1'b1));
    send_point(make_point(24'h444444, 24'h555555, 24'h666666, 19'd1, 1'b0));
  endtask

  // Total above the frame limit clamps; stride 9 picks points 0 and 9,
  // then an early frame_start abandons the frame.
  task automatic test_oversize_and_abandon();
    send_point(make_point(rand_coord(), rand_coord(), rand_coord(), 19'h7FFFF, 1'b1));
    for (int k = 1; k < 10; k++) send_point(rand_point(1'b0, 0));
    send_point(make_point(24'h7FFFFF, 24'h800000, 24'h000001, 19'd2, 1'b1));
    send_point(rand_point(1'b0, 0));
  endtask

  // Largest coefficients and offsets push both ends into saturation.
  task automatic test_transform_saturation();
    write_all_regs(1'b1, 16'hFFFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
                   48'h7FFF_7FFF_7FFF, 60'h7FFFF_7FFFF_7FFFF);
    send_point(make_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 19'd2, 1'b1));
    send_point(make_point(24'h800000, 24'h800000, 24'h800000, 19'd0, 1'b0));
  endtask

  // A point cap of 0 behaves as 1: one point per frame, marked last.
  task automatic test_zero_point_cap();
    write_all_regs(1'b1, 16'h0000, 48'h8000_8000_8000, 48'h8000_8000_8000,
                   48'h8000_8000_8000, 60'h80000_80000_80000);
    send_point(make_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 19'd3, 1'b1));
    send_point(rand_point(1'b0, 0));
    send_point(rand_point(1'b0, 0));
  endtask

  task automatic test_random_traffic();
    int base;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_random_config();
      base = items_sent;
      while (items_sent - base < PHASE_ITEMS) send_random_frame();
    end
  endtask

  initial begin
    // hold reset, then release it at a falling edge
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_frame_basics();
    test_empty_frame();
    test_oversize_and_abandon();
    test_transform_saturation();
    test_zero_point_cap();
    test_random_traffic();

    // drain everything still in flight before judging the run
    wait_idle();
    if (err_count == 0) begin
      $display("point_decimate_rigid_transform_core_test: done, clean");
    end else begin
      $display("point_decimate_rigid_transform_core_test: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/pdrt_pkg.sv
design/pdrt_div.sv
design/pdrt_fifo.sv
design/pdrt_front.sv
design/pdrt_back.sv
design/point_decimate_rigid_transform_core.sv
verif/point_decimate_rigid_transform_core_test.sv
